// ===== src/wvp_pkg.sv =====
// ----------------------------------------------------------------------------
// wvp_pkg
// Shared constants for the world-to-viewport projection core: configuration
// register indexes, port widths and fixed-point scaling constants.
// ----------------------------------------------------------------------------
package wvp_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Field widths fixed by the interface
  localparam int COORD_W = 32;
  localparam int BASIS_W = 16;
  localparam int SCALE_W = 24;

  // Fraction bits of the scale factors
  localparam int SCALE_FRAC = 16;

  // Magnitude cap exponent: view magnitudes clamp at 2^CAP_EXP
  localparam int CAP_EXP = 62;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_XY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Z     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_UP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_FORWARD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORTHO_MODE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE       = 3'd7;

endpackage

// ===== src/world_to_viewport_projection_core.sv =====
// ----------------------------------------------------------------------------
// world_to_viewport_projection_core
// Moves a world point into camera space and projects it to normalized
// viewport coordinates, orthographic or perspective, with view depth.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one world point per transfer.
//   Result channel (out_valid / out_stall) gives view x, view y, depth and
//   the behind-camera and saturated flags for each point, in order.
//   Configuration registers are written through cfg_we / cfg_index /
//   cfg_wdata while no point is in flight.
// Pipeline: three stages for the camera-space dot products, one for the
//   scale multiply, one to set up the divide, 62 quotient stages of a
//   restoring divider (one bit each), and the output register.
// Throughput: one point per cycle; the whole pipeline moves every cycle in
//   which the output register is empty or being taken.
// Stall: while out_stall holds a waiting result, every stage holds and
//   in_stall is raised; nothing is dropped or repeated.
// Reset: all stage valid bits clear, registers return to identity basis,
//   camera at origin, perspective mode and unit scales.
// ----------------------------------------------------------------------------
module world_to_viewport_projection_core
  import wvp_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int BASIS_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_W-1:0]    in_world_x,
  input  logic signed [COORD_W-1:0]    in_world_y,
  input  logic signed [COORD_W-1:0]    in_world_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_W-1:0]    out_view_x,
  output logic signed [COORD_W-1:0]    out_view_y,
  output logic signed [COORD_W-1:0]    out_view_depth,
  output logic                         out_behind_camera,
  output logic                         out_saturated
);

  // Datapath widths
  localparam int DW   = COORD_W + 1;               // position difference
  localparam int PW   = DW + BASIS_W;              // one product
  localparam int SW   = PW + 3;                    // sum of three plus rounding
  localparam int LW   = SW - BASIS_FRAC_BITS;      // local coordinate
  localparam int AZW  = LW;                        // |depth|
  localparam int NW   = LW + SCALE_W;              // |local| * scale
  localparam int DVW  = NW + COORD_FRAC_BITS;      // dividend
  localparam int QB   = CAP_EXP;                   // quotient bits below cap
  localparam int K    = CAP_EXP - COORD_FRAC_BITS; // overflow compare shift
  localparam int OVW  = NW + AZW + K;
  localparam int MW   = CAP_EXP + 1;               // capped magnitude
  localparam int EW   = (NW > MW) ? NW : MW;
  localparam int RW   = MW + 1 - (SCALE_FRAC + 1); // rounded magnitude
  localparam int FW   = RW + 2;                    // signed finish value
  localparam logic [MW-1:0] CAP = MW'(1) << CAP_EXP;

  typedef struct packed {
    logic [COORD_W-1:0] v;
    logic               sat;
  } fin_t;

  function automatic fin_t sat32_fw(input logic signed [FW-1:0] s);
    fin_t f;
    f.sat = (s[FW-1:COORD_W-1] != '0) && (s[FW-1:COORD_W-1] != '1);
    f.v   = f.sat ? (s[FW-1] ? 32'h8000_0000 : 32'h7fff_ffff) : s[COORD_W-1:0];
    return f;
  endfunction

  // Scale 0.5, round half away from zero, sign, offset by 0.5, clamp
  function automatic fin_t finish(input logic [MW-1:0] m, input logic neg);
    logic [MW:0]          t;
    logic [RW-1:0]        r;
    logic signed [FW-1:0] s;
    fin_t                 f;
    t = {1'b0, m} + ((MW + 1)'(1) << SCALE_FRAC);
    r = RW'(t >> (SCALE_FRAC + 1));
    s = neg ? -$signed({2'b00, r}) : $signed({2'b00, r});
    s = s + (FW'(1) << (COORD_FRAC_BITS - 1));
    f = sat32_fw(s);
    return f;
  endfunction

  function automatic fin_t sat32_lw(input logic signed [LW-1:0] s);
    fin_t f;
    f.sat = (s[LW-1:COORD_W-1] != '0) && (s[LW-1:COORD_W-1] != '1);
    f.v   = f.sat ? (s[LW-1] ? 32'h8000_0000 : 32'h7fff_ffff) : s[COORD_W-1:0];
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2*COORD_W-1:0] cam_pos_xy_r;
  logic [COORD_W-1:0]   cam_pos_z_r;
  logic [3*BASIS_W-1:0] basis_r [3];
  logic                 ortho_mode_r;
  logic [SCALE_W-1:0]   x_scale_r;
  logic [SCALE_W-1:0]   y_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_pos_xy_r <= '0;
      cam_pos_z_r  <= '0;
      basis_r[0]   <= 48'd16384;
      basis_r[1]   <= 48'd1073741824;
      basis_r[2]   <= 48'd70368744177664;
      ortho_mode_r <= 1'b0;
      x_scale_r    <= 24'd65536;
      y_scale_r    <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_POS_XY:    cam_pos_xy_r <= cfg_wdata;
        REG_CAM_POS_Z:     cam_pos_z_r  <= cfg_wdata[COORD_W-1:0];
        REG_BASIS_RIGHT:   basis_r[0]   <= cfg_wdata[3*BASIS_W-1:0];
        REG_BASIS_UP:      basis_r[1]   <= cfg_wdata[3*BASIS_W-1:0];
        REG_BASIS_FORWARD: basis_r[2]   <= cfg_wdata[3*BASIS_W-1:0];
        REG_ORTHO_MODE:    ortho_mode_r <= cfg_wdata[0];
        REG_X_SCALE:       x_scale_r    <= cfg_wdata[SCALE_W-1:0];
        REG_Y_SCALE:       y_scale_r    <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: everything moves when the output register frees up
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // Stage 1: subtract camera position
  // --------------------------------------------------------------------------
  logic                 v1_r;
  logic signed [DW-1:0] d_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r[0] <= DW'(in_world_x) - DW'($signed(cam_pos_xy_r[COORD_W-1:0]));
      d_r[1] <= DW'(in_world_y) - DW'($signed(cam_pos_xy_r[2*COORD_W-1:COORD_W]));
      d_r[2] <= DW'(in_world_z) - DW'($signed(cam_pos_z_r));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: nine products, basis b times component c
  // --------------------------------------------------------------------------
  logic                 v2_r;
  logic signed [PW-1:0] pr_r [3][3];

  for (genvar b = 0; b < 3; b++) begin : g_prod_b
    for (genvar c = 0; c < 3; c++) begin : g_prod_c
      always_ff @(posedge clk) begin
        if (adv) begin
          pr_r[b][c] <= PW'(d_r[c]) *
                        PW'($signed(basis_r[b][c*BASIS_W +: BASIS_W]));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum, round half up, floor to coordinate fraction
  // --------------------------------------------------------------------------
  logic                 v3_r;
  logic signed [LW-1:0] loc_r [3];

  for (genvar b = 0; b < 3; b++) begin : g_sum
    logic signed [SW-1:0] sum;
    assign sum = SW'(pr_r[b][0]) + SW'(pr_r[b][1]) + SW'(pr_r[b][2]) +
                 (SW'(1) << (BASIS_FRAC_BITS - 1));
    always_ff @(posedge clk) begin
      if (adv) begin
        loc_r[b] <= LW'(sum >>> BASIS_FRAC_BITS);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitudes, scale multiply, result signs
  // --------------------------------------------------------------------------
  logic                 v4_r;
  logic [NW-1:0]        n4_r   [2];
  logic                 neg4_r [2];
  logic [AZW-1:0]       az4_r;
  logic signed [LW-1:0] lz4_r;
  logic [LW-1:0]        mag_x, mag_y;

  assign mag_x = loc_r[0][LW-1] ? LW'(-loc_r[0]) : LW'(loc_r[0]);
  assign mag_y = loc_r[1][LW-1] ? LW'(-loc_r[1]) : LW'(loc_r[1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      n4_r[0]   <= NW'(mag_x) * NW'(x_scale_r);
      n4_r[1]   <= NW'(mag_y) * NW'(y_scale_r);
      neg4_r[0] <= loc_r[0][LW-1] ^ (!ortho_mode_r && loc_r[2][LW-1]);
      neg4_r[1] <= loc_r[1][LW-1] ^ (!ortho_mode_r && loc_r[2][LW-1]);
      az4_r     <= loc_r[2][LW-1] ? AZW'(-loc_r[2]) : AZW'(loc_r[2]);
      lz4_r     <= loc_r[2];
    end
  end

  // --------------------------------------------------------------------------
  // Divider: stage 0 sets up, stages 1..QB give one quotient bit each
  // --------------------------------------------------------------------------
  logic                 dv_v_r  [QB+1];
  logic [AZW-1:0]       dv_az_r [QB+1];
  logic signed [LW-1:0] dv_lz_r [QB+1];
  logic [DVW-1:0]       dv_d_r  [2][QB+1];
  logic [AZW-1:0]       dv_rm_r [2][QB+1];
  logic [QB-1:0]        dv_q_r  [2][QB+1];
  logic                 dv_ov_r [2][QB+1];
  logic                 dv_ng_r [2][QB+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_az_r[0] <= az4_r;
      dv_lz_r[0] <= lz4_r;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DVW-1:0] dvd;
    logic           ovf;

    // Quotient of 2^CAP_EXP or more (or a zero divisor with a nonzero numerator) saturates
    assign dvd = {n4_r[l], {COORD_FRAC_BITS{1'b0}}};
    assign ovf = !ortho_mode_r && (n4_r[l] != '0) &&
                 (OVW'(n4_r[l]) >= (OVW'(az4_r) << K));

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_d_r[l][0]  <= dvd;
        dv_rm_r[l][0] <= AZW'(dvd >> QB);
        dv_q_r[l][0]  <= '0;
        dv_ov_r[l][0] <= ovf;
        dv_ng_r[l][0] <= neg4_r[l];
      end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
      logic [AZW:0] t;
      logic         ge;
      // a zero divisor over a zero numerator leaves a zero quotient
      assign t  = {dv_rm_r[l][j], dv_d_r[l][j][QB-1-j]};
      assign ge = (dv_az_r[j] != '0) && (t >= {1'b0, dv_az_r[j]});
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_d_r[l][j+1]  <= dv_d_r[l][j];
          dv_rm_r[l][j+1] <= ge ? AZW'(t - {1'b0, dv_az_r[j]}) : AZW'(t);
          dv_q_r[l][j+1]  <= dv_q_r[l][j] | (QB'(ge) << (QB-1-j));
          dv_ov_r[l][j+1] <= dv_ov_r[l][j];
          dv_ng_r[l][j+1] <= dv_ng_r[l][j];
        end
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_share
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_az_r[j+1] <= dv_az_r[j];
        dv_lz_r[j+1] <= dv_lz_r[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits travel with the data
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j <= QB; j++) begin
        dv_v_r[j] <= 1'b0;
      end
    end else if (adv) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      dv_v_r[0] <= v4_r;
      for (int j = 0; j < QB; j++) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      out_valid_r <= dv_v_r[QB];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: choose magnitude, finish, clamp
  // --------------------------------------------------------------------------
  logic [MW-1:0]        m_sel [2];
  fin_t                 f_x, f_y, f_d;
  logic [COORD_W-1:0]   vx_r, vy_r, vd_r;
  logic                 behind_r, sat_r;

  for (genvar l = 0; l < 2; l++) begin : g_msel
    logic [NW-1:0] n_end;
    assign n_end = NW'(dv_d_r[l][QB] >> COORD_FRAC_BITS);
    always_comb begin
      if (ortho_mode_r) begin
        m_sel[l] = (EW'(n_end) > EW'(CAP)) ? CAP : MW'(n_end);
      end else if (dv_ov_r[l][QB]) begin
        m_sel[l] = CAP;
      end else begin
        m_sel[l] = MW'(dv_q_r[l][QB]);
      end
    end
  end

  assign f_x = finish(m_sel[0], dv_ng_r[0][QB]);
  assign f_y = finish(m_sel[1], dv_ng_r[1][QB]);
  assign f_d = sat32_lw(dv_lz_r[QB]);

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r     <= f_x.v;
      vy_r     <= f_y.v;
      vd_r     <= f_d.v;
      behind_r <= !ortho_mode_r && (dv_lz_r[QB] <= 0);
      sat_r    <= f_x.sat || f_y.sat || f_d.sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_view_x        = vx_r;
  assign out_view_y        = vy_r;
  assign out_view_depth    = vd_r;
  assign out_behind_camera = behind_r;
  assign out_saturated     = sat_r;

endmodule

// ===== src/wvp_checker.sv =====
// ----------------------------------------------------------------------------
// wvp_checker
// Port-level checks on the projection core, attached by bind.
// ----------------------------------------------------------------------------
module wvp_checker
  import wvp_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      cfg_we,
  input logic [CFG_IDX_W-1:0]      cfg_index,
  input logic [CFG_DATA_W-1:0]     cfg_wdata,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic signed [COORD_W-1:0] in_world_x,
  input logic signed [COORD_W-1:0] in_world_y,
  input logic signed [COORD_W-1:0] in_world_z,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [COORD_W-1:0] out_view_x,
  input logic signed [COORD_W-1:0] out_view_y,
  input logic signed [COORD_W-1:0] out_view_depth,
  input logic                      out_behind_camera,
  input logic                      out_saturated
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_view_x) &&
      $stable(out_view_y) && $stable(out_view_depth) &&
      $stable(out_behind_camera) && $stable(out_saturated))
    else $error("stalled result changed");

  // The input side only stalls behind a waiting result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // Behind-camera flag only with non-positive depth
  a_behind_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_behind_camera |-> out_view_depth <= 0)
    else $error("behind_camera with positive depth");

endmodule

bind world_to_viewport_projection_core wvp_checker u_wvp_checker (.*);

// ===== tb/world_to_viewport_projection_core_tb.sv =====
// ----------------------------------------------------------------------------
// world_to_viewport_projection_core_tb
// Self-checking bench for the projection core. A table of directed points is
// run at the reset configuration, then random points through several register
// settings: orthographic and perspective, zero and full scales, and extreme
// camera positions. Each result is checked against its typed table row or an
// in-bench fixed-point projection model. Both channels idle in random bursts,
// and the receiver holds off once for a long stretch so that the pipeline fills.
// ----------------------------------------------------------------------------
module world_to_viewport_projection_core_tb;
  import wvp_pkg::*;

  localparam int LATENCY    = 68;
  localparam int WDOG_LIMIT = 5000;
  localparam int HOLD_LEN   = 300;
  localparam longint CAP    = 64'sd1 << CAP_EXP;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vd;
    logic        behind;
    logic        sat;
  } view_t;

  typedef struct {
    logic [31:0] x, y, z;
    bit          typed;
    view_t       res;
  } point_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] in_world_x = '0, in_world_y = '0, in_world_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_view_x, out_view_y, out_view_depth;
  logic out_behind_camera, out_saturated;

  // typed expectation that travels with the current point
  bit    pt_typed = 1'b0;
  view_t pt_res = '0;

  // shadow of the configuration registers
  logic [63:0] cam_xy;
  logic [31:0] cam_z;
  logic [47:0] b_right, b_up, b_fwd;
  logic        ortho;
  logic [23:0] xs, ys;

  view_t pending_views[$];
  int    errors = 0;
  bit    calm = 1'b0;      // no idling in the last part of the run
  bit    hold_req = 1'b0;
  int    quiet = 0;

  world_to_viewport_projection_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- projection model ----------------
  function automatic longint axis(longint dx, longint dy, longint dz, logic [47:0] b);
    longint s;
    s = dx * longint'($signed(b[15:0])) + dy * longint'($signed(b[31:16]))
      + dz * longint'($signed(b[47:32]));
    return (s + 64'sd8192) >>> 14;
  endfunction

  function automatic logic [31:0] clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  // floor(n * 2^16 / d), capped
  function automatic longint ratio(longint n, longint d);
    logic [127:0] q;
    if (d == 0) return n == 0 ? 0 : CAP;
    q = {64'd0, n} << 16;
    q = q / 128'(d);
    if (q >= CAP) return CAP;
    return q[63:0];
  endfunction

  // halve, round half away from zero, recenter on 0.5
  function automatic logic [31:0] to_view(longint m, bit neg, inout bit sat);
    longint r;
    if (m > CAP) m = CAP;
    r = (m + 64'sd65536) >>> 17;
    if (neg) r = -r;
    return clamp32(r + 64'sd32768, sat);
  endfunction

  function automatic view_t project(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
    view_t  v;
    bit     sat;
    longint dx, dy, dz, lx, ly, lz, az;
    sat = 1'b0;
    dx = longint'($signed(wx)) - longint'($signed(cam_xy[31:0]));
    dy = longint'($signed(wy)) - longint'($signed(cam_xy[63:32]));
    dz = longint'($signed(wz)) - longint'($signed(cam_z));
    lx = axis(dx, dy, dz, b_right);
    ly = axis(dx, dy, dz, b_up);
    lz = axis(dx, dy, dz, b_fwd);
    v.behind = 1'b0;
    if (ortho) begin
      v.vx = to_view(absv(lx) * longint'(xs), lx < 0, sat);
      v.vy = to_view(absv(ly) * longint'(ys), ly < 0, sat);
    end else begin
      az = absv(lz);
      v.behind = lz <= 0;
      v.vx = to_view(ratio(absv(lx) * longint'(xs), az), (lx < 0) != (lz < 0), sat);
      v.vy = to_view(ratio(absv(ly) * longint'(ys), az), (ly < 0) != (lz < 0), sat);
    end
    v.vd = clamp32(lz, sat);
    v.sat = sat;
    return v;
  endfunction

  // ---------------- transfer monitor and checker ----------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_views.push_back(pt_typed ? pt_res : project(in_world_x, in_world_y, in_world_z));
    if (rst_n && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: x=%h y=%h d=%h", $time,
                 out_view_x, out_view_y, out_view_depth);
      end else begin
        view_t e, a;
        e = pending_views.pop_front();
        a = '{out_view_x, out_view_y, out_view_depth, out_behind_camera, out_saturated};
        if (a.vx !== e.vx) begin
          errors++;
          $display("%0t: view_x expected %h actual %h", $time, e.vx, a.vx);
        end
        if (a.vy !== e.vy) begin
          errors++;
          $display("%0t: view_y expected %h actual %h", $time, e.vy, a.vy);
        end
        if (a.vd !== e.vd) begin
          errors++;
          $display("%0t: view_depth expected %h actual %h", $time, e.vd, a.vd);
        end
        if (a.behind !== e.behind) begin
          errors++;
          $display("%0t: behind_camera expected %b actual %b", $time, e.behind, a.behind);
        end
        if (a.sat !== e.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, e.sat, a.sat);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("world_to_viewport_projection_core_tb: FAIL");
      $finish;
    end
  end

  // ---------------- receiver stall ----------------
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_LEN; n++) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(1, 0)) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end
    end
  end

  // ---------------- driver tasks ----------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CAM_POS_XY:    cam_xy = val;
      REG_CAM_POS_Z:     cam_z = val[31:0];
      REG_BASIS_RIGHT:   b_right = val[47:0];
      REG_BASIS_UP:      b_up = val[47:0];
      REG_BASIS_FORWARD: b_fwd = val[47:0];
      REG_ORTHO_MODE:    ortho = val[0];
      REG_X_SCALE:       xs = val[23:0];
      default:           ys = val[23:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one point; returns at the edge where it was taken
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit typed,
                            view_t res, bit may_idle);
    if (may_idle && !calm && $urandom_range(7, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_world_x <= x;
    in_world_y <= y;
    in_world_z <= z;
    pt_typed <= typed;
    pt_res <= res;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] coord(logic [31:0] base);
    case ($urandom_range(5, 0))
      0:       return $urandom();
      1:       return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
      2:       return base;
      default: return base + 32'($signed($urandom_range(2097152, 0)) - 1048576);
    endcase
  endfunction

  function automatic logic [47:0] rand_basis(int axis_sel);
    logic [15:0] one;
    if ($urandom_range(2, 0) == 0) return 48'({$urandom(), $urandom()});
    one = $urandom_range(1, 0) ? 16'h4000 : 16'hc000;
    return 48'(one) << (16 * axis_sel);
  endfunction

  task automatic run_points(int count);
    logic [31:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      x = coord(cam_xy[31:0]);
      y = coord(cam_xy[63:32]);
      z = coord(cam_z);
      send_point(x, y, z, 1'b0, '0, 1'b1);
    end
  endtask

  // ---------------- directed points at reset settings ----------------
  point_row_t points[] = '{
    '{32'h0, 32'h0, 32'h0, 1'b1, '{32'h8000, 32'h8000, 32'h0, 1'b1, 1'b0}},
    '{32'h7fffffff, 32'h0, 32'h0, 1'b1, '{32'h7fffffff, 32'h8000, 32'h0, 1'b1, 1'b1}},
    '{32'h80000000, 32'h0, 32'h0, 1'b1, '{32'h80000000, 32'h8000, 32'h0, 1'b1, 1'b1}},
    '{32'h0, 32'h7fffffff, 32'h0, 1'b1, '{32'h8000, 32'h7fffffff, 32'h0, 1'b1, 1'b1}},
    '{32'h0, 32'h0, 32'h10000, 1'b1, '{32'h8000, 32'h8000, 32'h10000, 1'b0, 1'b0}},
    '{32'h10000, 32'h10000, 32'h10000, 1'b0, '0},
    '{32'h10000, 32'hffff0000, 32'hffff0000, 1'b0, '0},
    '{32'h7fffffff, 32'h80000000, 32'h1, 1'b0, '0},
    '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0, '0},
    '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '0},
    '{32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, '0},
    '{32'h00008000, 32'hffff8000, 32'h00020000, 1'b0, '0}
  };

  // ---------------- main sequence ----------------
  initial begin
    logic [63:0] scale_x, scale_y;
    cam_xy = '0; cam_z = '0;
    b_right = 48'd16384; b_up = 48'd1073741824; b_fwd = 48'd70368744177664;
    ortho = 1'b0; xs = 24'd65536; ys = 24'd65536;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (points[i])
      send_point(points[i].x, points[i].y, points[i].z, points[i].typed, points[i].res, 1'b0);
    run_points(100);
    drain();

    // extreme settings, then random ones
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_CAM_POS_XY, 64'h7fffffff_7fffffff);
          write_reg(REG_CAM_POS_Z, 64'h7fffffff);
          scale_x = 64'hffffff; scale_y = 64'hffffff;
          write_reg(REG_ORTHO_MODE, 64'd1);
        end
        1: begin
          write_reg(REG_CAM_POS_XY, 64'h80000000_80000000);
          write_reg(REG_CAM_POS_Z, 64'h80000000);
          scale_x = 64'd0; scale_y = 64'd0;
          write_reg(REG_ORTHO_MODE, 64'd0);
        end
        2: begin
          write_reg(REG_CAM_POS_XY, 64'd0);
          write_reg(REG_CAM_POS_Z, 64'd0);
          scale_x = 64'hffffff; scale_y = 64'd0;
        end
        default: begin
          write_reg(REG_CAM_POS_XY, {$urandom(), $urandom()});
          write_reg(REG_CAM_POS_Z, 64'($urandom()));
          scale_x = $urandom_range(1, 0) ? 64'($urandom_range(24'hffffff, 0))
                                         : 64'($urandom_range(24'h030000, 24'h004000));
          scale_y = $urandom_range(1, 0) ? 64'($urandom_range(24'hffffff, 0))
                                         : 64'($urandom_range(24'h030000, 24'h004000));
          write_reg(REG_ORTHO_MODE, 64'($urandom_range(1, 0)));
        end
      endcase
      write_reg(REG_BASIS_RIGHT, ph == 0 ? {$urandom(), $urandom()} : 64'(rand_basis(0)));
      write_reg(REG_BASIS_UP, 64'(rand_basis(1)));
      write_reg(REG_BASIS_FORWARD, 64'(rand_basis(2)));
      write_reg(REG_X_SCALE, scale_x);
      write_reg(REG_Y_SCALE, scale_y);
      @(posedge clk);
      if (ph == 4) hold_req = 1'b1;
      if (ph == 8) calm = 1'b1;
      run_points(170);
      drain();
    end

    if (errors == 0)
      $display("world_to_viewport_projection_core_tb: PASS");
    else
      $display("world_to_viewport_projection_core_tb: FAIL");
    $finish;
  end

endmodule
